/* sv/swde_pkg.sv */
package swde_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int SAMPLE_MAX = 8388607;
    localparam int SAMPLE_MIN = -8388608;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Q15 gain, at most about 1.35 * 2.0
    localparam int GAIN_W   = 17;
    // side2 before and after the 0.7071 scale
    localparam int SIDE_W   = 27;
    // scaled side after the gain
    localparam int SIDEV_W  = 29;
    localparam int PROD_W   = SIDE_W + GAIN_W + 1;

    localparam int BYPASS_MAX    = 3;
    localparam int AMOUNT_MAX    = 32768;
    localparam int BOOST_Q15     = 44237;
    localparam int INV_SQRT2_Q15 = 23170;
    localparam int GAIN_SHIFT    = 30;
    localparam int INVS_SHIFT    = 15;
    localparam int SIDE_SHIFT    = 16;

    // tap delay = (rate * tenths_ms + 5000) / 10000
    // divide: (x >> 4) * ceil(2^32 / 625) >> 32, exact for x below 2^26
    localparam int NUM_TAPS     = 4;
    localparam int TAP_ROUND    = 5000;
    localparam int QUOT_W       = 13;
    localparam int DIV_W        = 26;
    localparam int RECIP_PRE    = 4;
    localparam int RECIP_W      = 23;
    localparam int RECIP_SHIFT  = 32;
    localparam int RECIP_PROD_W = DIV_W - RECIP_PRE + RECIP_W;
    localparam logic [RECIP_W-1:0] TAP_RECIP = 23'd6871948;
    localparam logic [7:0] TAP_TENTHS_MICRO   = 8'd25;
    localparam logic [7:0] TAP_TENTHS_HAAS    = 8'd150;
    localparam logic [7:0] TAP_TENTHS_DECOR_A = 8'd70;
    localparam logic [7:0] TAP_TENTHS_DECOR_B = 8'd230;
    localparam int TAP_MICRO   = 0;
    localparam int TAP_HAAS    = 1;
    localparam int TAP_DECOR_A = 2;
    localparam int TAP_DECOR_B = 3;

    localparam logic [15:0] AMOUNT_RST = 16'd0;
    localparam logic [15:0] DEPTH_RST  = 16'd32768;
    localparam logic [17:0] RATE_RST   = 18'd48000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_AMOUNT   = 3'd0,
        CFG_WIDTH_DEPTH    = 3'd1,
        CFG_WIDTH_MODE     = 3'd2,
        CFG_MONO_SOURCE    = 3'd3,
        CFG_SAMPLE_RATE_HZ = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_MICRO = 2'd0,
        MODE_HAAS  = 2'd1,
        MODE_DECOR = 2'd2,
        MODE_NONE  = 2'd3
    } width_mode_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_WRITE,
        CS_READB,
        CS_SIDE,
        CS_MULK,
        CS_RNDK,
        CS_MULG,
        CS_RNDG,
        CS_OUT,
        CS_BYPASS
    } ctrl_state_t;

    typedef enum logic [2:0] {
        CF_TAP_MUL,
        CF_TAP_DIV,
        CF_TAP_STORE,
        CF_GAIN_MUL1,
        CF_GAIN_MUL2,
        CF_GAIN_RND,
        CF_IDLE
    } coef_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } swde_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } swde_out_t;

    typedef struct packed {
        logic load_in;
        logic write_mono;
        logic read_b;
        logic form_side;
        logic mul_k;
        logic round_k;
        logic mul_g;
        logic round_g;
        logic out_load;
        logic out_bypass;
    } swde_cmd_t;

    typedef struct packed {
        logic out_free;
    } swde_dp_stat_t;

    typedef struct packed {
        logic ready;
        logic bypass;
        logic decor;
    } swde_cfg_stat_t;

    typedef struct packed {
        logic              mono_source;
        width_mode_t       mode;
        logic [GAIN_W-1:0] gain;
    } swde_coef_t;

endpackage

/* sv/swde_ram.sv */
module swde_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/swde_cfg.sv */
module swde_cfg #(
    parameter int DELAY_DEPTH = 8192
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [swde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swde_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output swde_pkg::swde_cfg_stat_t            stat,
    output swde_pkg::swde_coef_t                coef,
    output logic [$clog2(DELAY_DEPTH)-1:0]      tap_a,
    output logic [$clog2(DELAY_DEPTH)-1:0]      tap_b
);
    import swde_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [AW-1:0]    TAP_MAX  = AW'(DELAY_DEPTH - 1);

    logic [15:0]  amount_reg;
    logic [15:0]  depth_reg;
    width_mode_t  mode_reg;
    logic         mono_reg;
    logic [17:0]  rate_reg;

    coef_state_t  state_reg, state_next;
    logic [1:0]   idx_reg;
    logic [DIV_W-1:0]        num_reg;
    logic [RECIP_PROD_W-1:0] recip_reg;
    logic [AW-1:0]     taps_reg [NUM_TAPS];
    logic [31:0]       g1_reg;
    logic [47:0]       g2_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic [15:0]       amt_clip;
    logic [7:0]        tenths;
    logic [DIV_W-1:0]  scaled_rate;
    logic [QUOT_W-1:0] quot;
    logic [AW-1:0]     tap_clamped;
    logic              ready;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amount_reg <= AMOUNT_RST;
            depth_reg  <= DEPTH_RST;
            mode_reg   <= MODE_MICRO;
            mono_reg   <= 1'b0;
            rate_reg   <= RATE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH_AMOUNT:   amount_reg <= cfg_wdata[15:0];
                CFG_WIDTH_DEPTH:    depth_reg  <= cfg_wdata[15:0];
                CFG_WIDTH_MODE:     mode_reg   <= width_mode_t'(cfg_wdata[1:0]);
                CFG_MONO_SOURCE:    mono_reg   <= cfg_wdata[0];
                CFG_SAMPLE_RATE_HZ: rate_reg   <= cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    // coefficient sequencer: four tap delays by reciprocal multiply, then the gain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CF_TAP_MUL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ready      = 1'b0;
        case (state_reg)
            CF_TAP_MUL:   state_next = CF_TAP_DIV;
            CF_TAP_DIV:   state_next = CF_TAP_STORE;
            CF_TAP_STORE: begin
                state_next = (idx_reg == 2'(NUM_TAPS - 1)) ? CF_GAIN_MUL1 : CF_TAP_MUL;
            end
            CF_GAIN_MUL1: state_next = CF_GAIN_MUL2;
            CF_GAIN_MUL2: state_next = CF_GAIN_RND;
            CF_GAIN_RND:  state_next = CF_IDLE;
            CF_IDLE:      ready = 1'b1;
            default:      state_next = CF_IDLE;
        endcase
        if (cfg_we) begin
            state_next = CF_TAP_MUL;
            ready      = 1'b0;
        end
    end

    always_comb begin
        case (idx_reg)
            2'(TAP_MICRO):   tenths = TAP_TENTHS_MICRO;
            2'(TAP_HAAS):    tenths = TAP_TENTHS_HAAS;
            2'(TAP_DECOR_A): tenths = TAP_TENTHS_DECOR_A;
            default:         tenths = TAP_TENTHS_DECOR_B;
        endcase
    end

    assign amt_clip    = (amount_reg > 16'(AMOUNT_MAX)) ? 16'(AMOUNT_MAX) : amount_reg;
    assign scaled_rate = DIV_W'(rate_reg) * DIV_W'(tenths) + DIV_W'(TAP_ROUND);
    assign quot        = recip_reg[RECIP_SHIFT +: QUOT_W];

    always_comb begin
        if (quot == '0) begin
            tap_clamped = AW'(1);
        end else if (32'(quot) > 32'(DELAY_DEPTH - 1)) begin
            tap_clamped = TAP_MAX;
        end else begin
            tap_clamped = AW'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cfg_we) begin
            idx_reg <= '0;
        end else if (state_reg == CF_TAP_STORE) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            CF_TAP_MUL:   num_reg <= scaled_rate;
            CF_TAP_DIV:   recip_reg <= RECIP_PROD_W'(num_reg[DIV_W-1:RECIP_PRE])
                                       * RECIP_PROD_W'(TAP_RECIP);
            CF_TAP_STORE: taps_reg[idx_reg] <= tap_clamped;
            CF_GAIN_MUL1: g1_reg <= 32'(amt_clip) * 32'(depth_reg);
            CF_GAIN_MUL2: g2_reg <= 48'(g1_reg) * 48'(BOOST_Q15);
            CF_GAIN_RND:  gain_reg <= GAIN_W'((g2_reg + (48'd1 << (GAIN_SHIFT - 1)))
                                             >> GAIN_SHIFT);
            default: ;
        endcase
    end

    always_comb begin
        case (mode_reg)
            MODE_MICRO: tap_a = taps_reg[TAP_MICRO];
            MODE_HAAS:  tap_a = taps_reg[TAP_HAAS];
            default:    tap_a = taps_reg[TAP_DECOR_A];
        endcase
    end
    assign tap_b = taps_reg[TAP_DECOR_B];

    assign stat.ready  = ready;
    assign stat.bypass = (amount_reg <= 16'(BYPASS_MAX));
    assign stat.decor  = (mode_reg == MODE_DECOR);

    assign coef.mono_source = mono_reg;
    assign coef.mode        = mode_reg;
    assign coef.gain        = gain_reg;

    a_write_drops_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !stat.ready)
        else $error("coefficient unit ready right after a register write");

    a_taps_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.ready |-> (tap_a != '0) && (tap_b != '0))
        else $error("tap delay of zero while coefficients ready");

endmodule

/* sv/swde_dp.sv */
module swde_dp #(
    parameter int DELAY_DEPTH = 8192
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  swde_pkg::swde_in_t                s_data,
    output swde_pkg::swde_out_t               m_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    input  swde_pkg::swde_cmd_t               cmd,
    output swde_pkg::swde_dp_stat_t           stat,
    input  swde_pkg::swde_coef_t              coef,
    input  logic [$clog2(DELAY_DEPTH)-1:0]    tap_a,
    input  logic [$clog2(DELAY_DEPTH)-1:0]    tap_b
);
    import swde_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);

    swde_in_t                   in_reg;
    logic signed [SAMPLE_W-1:0] mono_reg;
    logic signed [SAMPLE_W-1:0] ta_reg;
    logic                       valid_a_reg, valid_b_reg;
    logic signed [SIDE_W-1:0]   side_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SIDEV_W-1:0]  sidev_reg;
    swde_out_t                  out_reg;
    logic                       m_valid_reg;
    logic [AW-1:0]              wp_reg;
    logic [AW:0]                fill_reg;

    logic signed [SAMPLE_W:0]   sum_lr;
    logic signed [SAMPLE_W-1:0] mono_c;
    logic [AW-1:0]              addr_a, addr_b, ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_s;
    logic signed [SIDE_W-1:0]   m_x, a_x, b_x, side_c;
    logic signed [GAIN_W:0]     mul_b;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [SIDEV_W:0]    lo_s, ro_s;
    swde_out_t                  out_c;

    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wp,
                                                input logic [AW-1:0] back);
        logic [AW:0] sum;
        if (wp >= back) begin
            sum = {1'b0, wp} - {1'b0, back};
        end else begin
            sum = {1'b0, wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, back};
        end
        return sum[AW-1:0];
    endfunction

    // round to nearest, halves away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
                                                           input int sh);
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (sh - 1);
        if (v[PROD_W-1]) begin
            return (v + half - PROD_W'(1)) >>> sh;
        end
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SIDEV_W:0] v);
        if (v > (SIDEV_W+1)'(SAMPLE_MAX)) begin
            return SAMPLE_W'(SAMPLE_MAX);
        end
        if (v < (SIDEV_W+1)'(SAMPLE_MIN)) begin
            return SAMPLE_W'(SAMPLE_MIN);
        end
        return SAMPLE_W'(v);
    endfunction

    // floor((l + r) / 2)
    assign sum_lr = (SAMPLE_W+1)'(in_reg.left_in) + (SAMPLE_W+1)'(in_reg.right_in);
    assign mono_c = coef.mono_source ? in_reg.left_in : sum_lr[SAMPLE_W:1];

    assign addr_a    = back_addr(wp_reg, tap_a);
    assign addr_b    = back_addr(wp_reg, tap_b);
    assign ram_raddr = cmd.read_b ? addr_b : addr_a;

    swde_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DELAY_DEPTH)
    ) u_history (
        .aclk  (aclk),
        .we    (cmd.write_mono),
        .waddr (wp_reg),
        .wdata (mono_c),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_s = $signed(ram_rdata);

    // entries never written since reset read as zero
    assign m_x = SIDE_W'(mono_reg);
    assign a_x = SIDE_W'(ta_reg);
    assign b_x = valid_b_reg ? SIDE_W'(rd_s) : '0;

    always_comb begin
        case (coef.mode)
            MODE_MICRO: side_c = m_x - a_x;
            MODE_HAAS:  side_c = (m_x - a_x) <<< 1;
            MODE_DECOR: side_c = (m_x <<< 1) - a_x - b_x;
            default:    side_c = '0;
        endcase
    end

    assign mul_b  = cmd.mul_k ? (GAIN_W+1)'(INV_SQRT2_Q15) : $signed({1'b0, coef.gain});
    assign prod_c = side_reg * mul_b;

    assign lo_s = (SIDEV_W+1)'(mono_reg) + (SIDEV_W+1)'(sidev_reg);
    assign ro_s = (SIDEV_W+1)'(mono_reg) - (SIDEV_W+1)'(sidev_reg);

    always_comb begin
        if (cmd.out_bypass) begin
            out_c.left_out  = in_reg.left_in;
            out_c.right_out = coef.mono_source ? in_reg.left_in : in_reg.right_in;
        end else begin
            out_c.left_out  = sat_sample(lo_s);
            out_c.right_out = sat_sample(ro_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.write_mono) begin
            mono_reg    <= mono_c;
            valid_a_reg <= ({1'b0, tap_a} <= fill_reg);
        end
        if (cmd.read_b) begin
            ta_reg      <= valid_a_reg ? rd_s : '0;
            valid_b_reg <= ({1'b0, tap_b} <= fill_reg);
        end
        if (cmd.form_side) begin
            side_reg <= side_c;
        end else if (cmd.round_k) begin
            side_reg <= SIDE_W'(rnd_shift(prod_reg, INVS_SHIFT));
        end
        if (cmd.mul_k || cmd.mul_g) begin
            prod_reg <= prod_c;
        end
        if (cmd.round_g) begin
            sidev_reg <= SIDEV_W'(rnd_shift(prod_reg, SIDE_SHIFT));
        end
        if (cmd.out_load) begin
            out_reg <= out_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.read_b) begin
                wp_reg <= (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (fill_reg != (AW+1)'(DELAY_DEPTH)) begin
                    fill_reg <= fill_reg + (AW+1)'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_data        = out_reg;
    assign m_valid       = m_valid_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (AW+1)'(DELAY_DEPTH))
        else $error("history fill count beyond depth");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result valid without an output load");

endmodule

/* sv/swde_ctrl.sv */
module swde_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  swde_pkg::swde_cfg_stat_t cfg_st,
    input  swde_pkg::swde_dp_stat_t  dp_st,
    output swde_pkg::swde_cmd_t      cmd
);
    import swde_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_ready = cfg_st.ready;
                if (s_valid && cfg_st.ready) begin
                    cmd.load_in = 1'b1;
                    state_next  = cfg_st.bypass ? CS_BYPASS : CS_WRITE;
                end
            end
            CS_WRITE: begin
                // write mono, read first tap
                cmd.write_mono = 1'b1;
                state_next     = CS_READB;
            end
            CS_READB: begin
                cmd.read_b = 1'b1;
                state_next = CS_SIDE;
            end
            CS_SIDE: begin
                cmd.form_side = 1'b1;
                state_next    = cfg_st.decor ? CS_MULK : CS_MULG;
            end
            CS_MULK: begin
                cmd.mul_k  = 1'b1;
                state_next = CS_RNDK;
            end
            CS_RNDK: begin
                cmd.round_k = 1'b1;
                state_next  = CS_MULG;
            end
            CS_MULG: begin
                cmd.mul_g  = 1'b1;
                state_next = CS_RNDG;
            end
            CS_RNDG: begin
                cmd.round_g = 1'b1;
                state_next  = CS_OUT;
            end
            CS_OUT: begin
                if (dp_st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            CS_BYPASS: begin
                if (dp_st.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_bypass = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> dp_st.out_free)
        else $error("output register overwritten while holding a result");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample taken while one is in flight");

endmodule

/* sv/stereo_width_delay_enhancer_core.sv */
// Stereo width stage with a mono delay line (Haas style widener).
// Input channel s_*: one stereo sample pair per transfer (valid/ready).
// Result channel m_*: one widened pair per input transfer, in order.
// Registers are written through cfg_we/cfg_index/cfg_wdata: 0 width amount,
// 1 width depth, 2 mode, 3 mono source, 4 sample rate in Hz.
// Each pair runs through write, second read, side, gain multiply, gain round
// and output states (decorrelated adds the 0.7071 multiply and round; a
// bypassed pair goes straight to output). One pair is in flight at once. The
// delay RAM has a single read port, so the two taps are read in turn, and
// one multiplier handles both the 0.7071 scale and the gain.
// After reset, and after every register write, a coefficient sequencer works
// out tap delays and gain; s_ready stays low meanwhile.
// Reset empties the delay line through a fill count, so no clearing pass runs.
// A stalled receiver holds the result in the output register; the next pair
// is still taken and processed, and waits only for that register to drain.
module stereo_width_delay_enhancer_core #(
    parameter int DELAY_DEPTH = 8192
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  swde_pkg::swde_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output swde_pkg::swde_out_t             m_data,
    input  logic                            cfg_we,
    input  logic [swde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swde_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import swde_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);

    swde_cfg_stat_t cfg_st;
    swde_coef_t     coef;
    swde_dp_stat_t  dp_st;
    swde_cmd_t      cmd;
    logic [AW-1:0]  tap_a, tap_b;

    swde_cfg #(
        .DELAY_DEPTH(DELAY_DEPTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .stat      (cfg_st),
        .coef      (coef),
        .tap_a     (tap_a),
        .tap_b     (tap_b)
    );

    swde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cfg_st  (cfg_st),
        .dp_st   (dp_st),
        .cmd     (cmd)
    );

    swde_dp #(
        .DELAY_DEPTH(DELAY_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (dp_st),
        .coef    (coef),
        .tap_a   (tap_a),
        .tap_b   (tap_b)
    );

endmodule

/* dv/tb_stereo_width_delay_enhancer_core.sv */
module tb_stereo_width_delay_enhancer_core;
    import swde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH     = 8192;
    localparam int BOOST_GAIN_Q15 = 44237;   // 1.35
    localparam int HALF_ROOT2_Q15 = 23170;   // 0.7071
    localparam int TENTHS_MICRO   = 25;
    localparam int TENTHS_HAAS    = 150;
    localparam int TENTHS_DECOR_A = 70;
    localparam int TENTHS_DECOR_B = 230;
    localparam int RANDOM_PAIRS   = 1300;
    localparam int QUIET_FROM     = 1100;    // no idling past this many random pairs
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_RESULT = 150;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    swde_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    swde_out_t m_data;
    logic      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    stereo_width_delay_enhancer_core #(
        .DELAY_DEPTH(LINE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register mirror and delay line of the predictor
    logic [15:0]        amount_reg = 16'd0;
    logic [15:0]        depth_reg  = 16'd32768;
    width_mode_t        mode_reg   = MODE_MICRO;
    logic               mono_reg   = 1'b0;
    logic [17:0]        rate_reg   = 18'd48000;
    logic signed [23:0] mono_line [LINE_DEPTH];
    int                 line_wr_ptr = 0;

    swde_in_t  pending_pairs [$];
    swde_out_t expected_pairs [$];
    int pairs_queued = 0;
    int pairs_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    bit idle_on      = 1'b0;
    bit s_fire       = 1'b0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    initial begin
        foreach (mono_line[i]) mono_line[i] = '0;
    end

    function automatic longint round_away(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [23:0] clip24(longint v);
        if (v > SAMPLE_MAX) return 24'(SAMPLE_MAX);
        if (v < SAMPLE_MIN) return 24'(SAMPLE_MIN);
        return 24'(v);
    endfunction

    function automatic longint tap_len(int tenths);
        longint d;
        d = (longint'(rate_reg) * tenths + 5000) / 10000;
        if (d < 1) d = 1;
        if (d > LINE_DEPTH - 1) d = LINE_DEPTH - 1;
        return d;
    endfunction

    function automatic longint tap_value(int tenths);
        int idx;
        idx = (line_wr_ptr + LINE_DEPTH - int'(tap_len(tenths))) % LINE_DEPTH;
        return longint'(mono_line[idx]);
    endfunction

    // Widened pair for one input pair; advances the delay line unless bypassed.
    function automatic swde_out_t widen_sample(swde_in_t x);
        swde_out_t o;
        longint l, r, mono, side2, side, amt, gain;
        l = longint'($signed(x.left_in));
        r = longint'($signed(x.right_in));
        amt = (amount_reg > 16'd32768) ? 32768 : longint'(amount_reg);
        if (amt <= 3) begin
            o.left_out  = x.left_in;
            o.right_out = mono_reg ? x.left_in : x.right_in;
            return o;
        end
        mono = mono_reg ? l : ((l + r) >>> 1);
        // current sample goes in before the taps are read
        mono_line[line_wr_ptr] = 24'(mono);
        case (mode_reg)
            MODE_MICRO: side2 = mono - tap_value(TENTHS_MICRO);
            MODE_HAAS:  side2 = 2 * (mono - tap_value(TENTHS_HAAS));
            MODE_DECOR: side2 = round_away((2 * mono - tap_value(TENTHS_DECOR_A)
                                - tap_value(TENTHS_DECOR_B)) * HALF_ROOT2_Q15, 15);
            default:    side2 = 0;
        endcase
        line_wr_ptr = (line_wr_ptr + 1) % LINE_DEPTH;
        gain = (amt * longint'(depth_reg) * BOOST_GAIN_Q15 + (longint'(1) << 29)) >>> 30;
        side = round_away(side2 * gain, 16);
        o.left_out  = clip24(mono + side);
        o.right_out = clip24(mono - side);
        return o;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // input side: predict on every transfer; result side: compare in order
    always @(posedge aclk) begin : monitor
        swde_out_t want;
        s_fire = s_valid && s_ready;
        if (aresetn && s_fire) begin
            expected_pairs.push_back(widen_sample(s_data));
            pairs_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                want = expected_pairs.pop_front();
                if (m_data.left_out !== want.left_out)
                    report_mismatch($sformatf("left_out got %0d want %0d (result %0d)",
                        $signed(m_data.left_out), $signed(want.left_out), results_seen));
                if (m_data.right_out !== want.right_out)
                    report_mismatch($sformatf("right_out got %0d want %0d (result %0d)",
                        $signed(m_data.right_out), $signed(want.right_out), results_seen));
            end
            results_seen++;
        end
    end

    always @(negedge aclk) begin : driver
        logic     nv;
        swde_in_t nd;
        nv = s_valid;
        nd = s_data;
        if (!s_valid || s_fire) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_pairs.size() > 0) begin
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 12);
                end else begin
                    nd = pending_pairs.pop_front();
                    nv = 1'b1;
                end
            end
        end
        s_valid <= nv;
        s_data  <= nd;
    end

    always @(negedge aclk) begin : receiver
        logic nr;
        nr = 1'b1;
        if (hold_left > 0) begin
            nr = 1'b0;
            hold_left--;
        end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            // long hold-off so the block backs up into its input
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            nr = 1'b0;
        end else if (stall_left > 0) begin
            nr = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            nr = 1'b0;
        end
        m_ready <= nr;
    end

    task automatic apply_settings(logic [15:0] amt, logic [15:0] dep, width_mode_t md,
                                  logic mono, logic [17:0] rate);
        cfg_index_t            regs [5];
        logic [CFG_DATA_W-1:0] vals [5];
        regs = '{CFG_WIDTH_AMOUNT, CFG_WIDTH_DEPTH, CFG_WIDTH_MODE, CFG_MONO_SOURCE,
                 CFG_SAMPLE_RATE_HZ};
        vals = '{CFG_DATA_W'(amt), CFG_DATA_W'(dep), CFG_DATA_W'(md), CFG_DATA_W'(mono),
                 rate};
        for (int i = 0; i < 5; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
        end
        @(negedge aclk);
        cfg_we     <= 1'b0;
        amount_reg = amt;
        depth_reg  = dep;
        mode_reg   = md;
        mono_reg   = mono;
        rate_reg   = rate;
    endtask

    task automatic send_pair(int l, int r);
        swde_in_t p;
        p.left_in  = 24'(l);
        p.right_in = 24'(r);
        pending_pairs.push_back(p);
        pairs_queued++;
    endtask

    task automatic drain();
        while (pairs_sent != pairs_queued || expected_pairs.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return 0;
                    default: return -1;
                endcase
            end
            1: return int'($urandom_range(0, 2000)) - 1000;
            default: return int'($signed(24'($urandom())));
        endcase
    endfunction

    initial begin
        int          done_random;
        int          n;
        logic [15:0] amt, dep;
        logic [17:0] rate;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // bypass at reset settings
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(-1, -2);
        drain();
        // amount at the bypass threshold, mono source copies left
        apply_settings(16'd3, 16'd32768, MODE_MICRO, 1'b1, 18'd48000);
        send_pair(12345, -54321);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        drain();
        // amount above full scale, max depth, haas: drives saturation
        apply_settings(16'hFFFF, 16'hFFFF, MODE_HAAS, 1'b0, 18'd48000);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(-3, 0);
        send_pair(0, 0);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        drain();
        // zero rate: every tap is one sample back
        apply_settings(16'd32768, 16'hFFFF, MODE_MICRO, 1'b0, 18'd0);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(1, 2);
        drain();
        // smallest active amount, largest rate field, decorrelated
        apply_settings(16'd4, 16'hFFFF, MODE_DECOR, 1'b0, 18'h3FFFF);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(-7, 4);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        drain();
        // no-side mode still writes the line
        apply_settings(16'd20000, 16'd0, MODE_NONE, 1'b1, 18'd8000);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(5, 7);
        drain();

        done_random = 0;
        while (done_random < RANDOM_PAIRS) begin
            case ($urandom_range(0, 9))
                0: amt = 16'($urandom_range(0, 3));
                1: amt = 16'd4;
                2: amt = 16'd32768;
                3: amt = 16'($urandom_range(32769, 65535));
                default: amt = 16'($urandom_range(4, 32768));
            endcase
            case ($urandom_range(0, 5))
                0: dep = 16'd0;
                1: dep = 16'hFFFF;
                default: dep = 16'($urandom());
            endcase
            // low rates keep the taps inside the part of the line already written
            case ($urandom_range(0, 7))
                0: rate = 18'd0;
                1: rate = 18'd8000;
                2: rate = 18'd192000;
                3: rate = 18'h3FFFF;
                4: rate = 18'($urandom_range(0, 18'h3FFFF));
                default: rate = 18'($urandom_range(8000, 24000));
            endcase
            apply_settings(amt, dep, width_mode_t'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), rate);
            idle_on = (done_random < QUIET_FROM);
            n = $urandom_range(60, 120);
            for (int i = 0; i < n; i++) send_pair(rand_sample(), rand_sample());
            done_random += n;
            drain();
        end

        if (expected_pairs.size() != 0) report_mismatch("results still pending at end");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
